@@ rtl/buffer_pool_clock_manager_macros.svh @@
// Assertion macros shared by the buffer pool manager RTL.
`ifndef BUFFER_POOL_CLOCK_MANAGER_MACROS_SVH
`define BUFFER_POOL_CLOCK_MANAGER_MACROS_SVH
`ifndef ASSERT_OFF
`define BPCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("bpcm: same-cycle check failed");
`define BPCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("bpcm: next-cycle check failed");
`else
`define BPCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bpcm_pkg.sv @@
// Shared types, codes and helpers of the buffer pool manager.
`timescale 1ns / 1ps
package bpcm_pkg;
	localparam int NUM_FRAMES_DEF = 64;
	localparam int MAX_PAGES_DEF  = 4096;
	localparam int FREE_DEPTH_DEF = 256;

	localparam int ACT_W     = 4;
	localparam int PAGE_W    = 12;
	localparam int PCNT_W    = 13;
	localparam int KIND_W    = 3;
	localparam int FRAME_W   = 6;
	localparam int STAT_W    = 2;
	localparam int PIN_W     = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [PIN_W-1:0] PIN_MAX = '1;

	localparam logic [ACT_W-1:0] ACT_PIN         = 4'd0;
	localparam logic [ACT_W-1:0] ACT_UNPIN       = 4'd1;
	localparam logic [ACT_W-1:0] ACT_ALLOCATE    = 4'd2;
	localparam logic [ACT_W-1:0] ACT_FREE        = 4'd3;
	localparam logic [ACT_W-1:0] ACT_COMMIT_SCAN = 4'd4;
	localparam logic [ACT_W-1:0] ACT_COMMIT_DONE = 4'd5;
	localparam logic [ACT_W-1:0] ACT_CHECKPOINT  = 4'd6;
	localparam logic [ACT_W-1:0] ACT_MARK_CLEAN  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_ROLLBACK    = 4'd8;

	localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HIT   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WBACK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LOG   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOFRAME = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOFILE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FILE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES    = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FRAME_W-1:0] frame;
		logic [PAGE_W-1:0]  page;
		logic [STAT_W-1:0]  status;
		logic               last;
	} res_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} dir_ctl_t;

	function automatic res_t mk_res(input logic [KIND_W-1:0] k, input logic [FRAME_W-1:0] f,
			input logic [PAGE_W-1:0] p, input logic [STAT_W-1:0] s, input logic l);
		res_t r;
		r.kind   = k;
		r.frame  = f;
		r.page   = p;
		r.status = s;
		r.last   = l;
		return r;
	endfunction
endpackage

@@ rtl/bpcm_dir.sv @@
// Page-to-frame directory memory with a clearing sweep after reset.
`timescale 1ns / 1ps
module bpcm_dir #(
	parameter int DEPTH = bpcm_pkg::MAX_PAGES_DEF,
	parameter int DW    = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bpcm_pkg::dir_ctl_t       ctl,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	output logic [DW-1:0]            rdata,
	output logic                     ready
);
	import bpcm_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_q;

	// walk every entry once after reset, marking it not resident
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (ctl.wr) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clr_q;
endmodule

@@ rtl/buffer_pool_clock_manager.sv @@
// Top level of the buffer pool frame manager with CLOCK replacement.
`timescale 1ns / 1ps
`include "buffer_pool_clock_manager_macros.svh"
// Usage:
//  - Request channel: drive action, page_id, mark_dirty and rollback_pages with start;
//    a request is taken on a clock edge where start is high and busy is low.
//  - Result channel: each result shows on kind/frame/page_number/status/last for
//    exactly one cycle with res_valid high. The receiver cannot stall; results are
//    never held. The final result of a request carries last.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//    always high. Write only while busy is low and no result is pending.
//  - Sequencing: range errors and simple actions end in the decode state; hits go
//    through lookup and hit, unpin through UP1 and UP2, free through FR1. A victim
//    search takes up to 2*NUM_FRAMES CLOCK steps, each on one frame and with a second
//    state for an occupied frame (its pin count comes from the frame memory), then
//    installs the page. Sweeps (commit scan, checkpoint, rollback) step through the
//    frames (to the last match, all for rollback), with a second state per frame read.
//    The next request can be taken in the cycle the final result is shown.
//  - Reset: after arst_n the directory is swept one entry per cycle over all MAX_PAGES
//    entries, with busy high; config writes are still taken during that sweep.
module buffer_pool_clock_manager #(
	parameter int NUM_FRAMES = bpcm_pkg::NUM_FRAMES_DEF,
	parameter int MAX_PAGES  = bpcm_pkg::MAX_PAGES_DEF,
	parameter int FREE_DEPTH = bpcm_pkg::FREE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [bpcm_pkg::ACT_W-1:0]     action,
	input  logic [bpcm_pkg::PAGE_W-1:0]    page_id,
	input  logic                           mark_dirty,
	input  logic [bpcm_pkg::PCNT_W-1:0]    rollback_pages,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bpcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpcm_pkg::PCNT_W-1:0]    cfg_data,
	output logic                           res_valid,
	output logic [bpcm_pkg::KIND_W-1:0]    kind,
	output logic [bpcm_pkg::FRAME_W-1:0]   frame,
	output logic [bpcm_pkg::PAGE_W-1:0]    page_number,
	output logic [bpcm_pkg::STAT_W-1:0]    status,
	output logic                           last
);
	import bpcm_pkg::*;

	localparam int FW   = $clog2(NUM_FRAMES);
	localparam int DAW  = $clog2(MAX_PAGES);
	localparam int PTW  = $clog2(MAX_PAGES + 1);
	localparam int FSW  = $clog2(FREE_DEPTH);
	localparam int FTW  = $clog2(FREE_DEPTH + 1);
	localparam int CW   = $clog2(2 * NUM_FRAMES + 1);
	localparam int DEW  = FW + 1;
	localparam int FMW  = PAGE_W + PIN_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEC  = 4'd1;
	localparam logic [3:0] ST_LOOK = 4'd2;
	localparam logic [3:0] ST_HIT  = 4'd3;
	localparam logic [3:0] ST_UP1  = 4'd4;
	localparam logic [3:0] ST_UP2  = 4'd5;
	localparam logic [3:0] ST_VIC  = 4'd6;
	localparam logic [3:0] ST_VIC2 = 4'd7;
	localparam logic [3:0] ST_PINV = 4'd8;
	localparam logic [3:0] ST_AL1  = 4'd9;
	localparam logic [3:0] ST_AL2  = 4'd10;
	localparam logic [3:0] ST_AL3  = 4'd11;
	localparam logic [3:0] ST_FR1  = 4'd12;
	localparam logic [3:0] ST_SW   = 4'd13;
	localparam logic [3:0] ST_SW2  = 4'd14;

	// control and request registers
	logic [3:0]        state_q;
	logic [ACT_W-1:0]  act_q;
	logic [PAGE_W-1:0] page_q;
	logic              mdirty_q;
	logic [PCNT_W-1:0] back_q;
	logic              fa_q, wr_q, lo_q;
	logic [PTW-1:0]    total_q;

	// per-frame flags, kept in flops so that bulk actions can see all frames
	logic [NUM_FRAMES-1:0] valid_q, dirty_q, logged_q, ref_q;

	logic [FW-1:0]     hand_q, vic_q, frm_q, idx_q;
	logic [CW-1:0]     cnt_q;
	logic [FTW-1:0]    free_top_q;
	logic [PAGE_W-1:0] id_q;

	res_t res_q;
	logic res_valid_q;

	// frame memory {page, pins} and free-id stack
	logic [FMW-1:0]    fmem_q [NUM_FRAMES];
	logic [FMW-1:0]    fm_rd_q;
	logic [PAGE_W-1:0] stk_q [FREE_DEPTH];
	logic [PAGE_W-1:0] stk_rd_q;

	logic [FW-1:0]     fm_raddr, fm_waddr;
	logic              fm_we;
	logic [FMW-1:0]    fm_wdata;
	logic              stk_we;
	logic [FSW-1:0]    stk_raddr, stk_waddr;

	dir_ctl_t          dctl;
	logic [DAW-1:0]    d_raddr, d_waddr;
	logic [DEW-1:0]    d_wdata, d_rd;
	logic              dir_ready;

	logic              d_ent_v;
	logic [FW-1:0]     d_ent_f;
	logic [PAGE_W-1:0] fm_rd_page;
	logic [PIN_W-1:0]  fm_rd_pins, pins_inc, pins_dec;
	logic [FW-1:0]     hand_nxt;
	logic              idx_end;

	logic              v_d, v_hard, v_rskip, v_nofile, v_take;
	logic [NUM_FRAMES-1:0] sw_match;
	logic              sw_more;
	logic              busy_w;

	assign d_ent_v    = d_rd[FW];
	assign d_ent_f    = d_rd[FW-1:0];
	assign fm_rd_page = fm_rd_q[FMW-1:PIN_W];
	assign fm_rd_pins = fm_rd_q[PIN_W-1:0];
	assign pins_inc   = (fm_rd_pins == PIN_MAX) ? fm_rd_pins : fm_rd_pins + 1'b1;
	assign pins_dec   = (fm_rd_pins == '0) ? fm_rd_pins : fm_rd_pins - 1'b1;
	assign hand_nxt   = (hand_q == FW'(NUM_FRAMES - 1)) ? '0 : hand_q + 1'b1;
	assign idx_end    = (idx_q == FW'(NUM_FRAMES - 1));

	// CLOCK decision for the occupied frame under the hand
	assign v_d      = dirty_q[vic_q];
	assign v_hard   = (fm_rd_pins != '0) || (v_d && !(wr_q && logged_q[vic_q]));
	assign v_rskip  = !v_hard && ref_q[vic_q];
	assign v_nofile = !v_hard && !ref_q[vic_q] && v_d && !fa_q;
	assign v_take   = !v_hard && !ref_q[vic_q] && !v_nofile;

	// frames a sweep acts on
	always_comb begin
		case (act_q)
			ACT_COMMIT_SCAN: sw_match = lo_q ? (valid_q & dirty_q & ~logged_q) : '0;
			ACT_CHECKPOINT:  sw_match = (wr_q && fa_q) ? (valid_q & dirty_q) : '0;
			default:         sw_match = valid_q & dirty_q;
		endcase
	end
	assign sw_more = |((sw_match >> idx_q) >> 1);

	assign busy_w = (state_q != ST_IDLE) || !dir_ready;

	// memory requests per state
	always_comb begin
		fm_raddr  = hand_q;
		fm_we     = 1'b0;
		fm_waddr  = frm_q;
		fm_wdata  = fm_rd_q;
		stk_we    = 1'b0;
		stk_waddr = FSW'(free_top_q);
		stk_raddr = FSW'(free_top_q - 1'b1);
		dctl      = '0;
		d_raddr   = DAW'(page_q);
		d_waddr   = DAW'(page_q);
		d_wdata   = '0;
		case (state_q)
			ST_DEC: begin
				dctl.rd = 1'b1;
			end
			ST_LOOK, ST_UP1: begin
				fm_raddr = d_ent_f;
			end
			ST_HIT: begin
				fm_we    = 1'b1;
				fm_wdata = {fm_rd_page, pins_inc};
			end
			ST_UP2: begin
				fm_we    = 1'b1;
				fm_wdata = {fm_rd_page, pins_dec};
			end
			ST_VIC2: begin
				dctl.wr = v_take;
				d_waddr = DAW'(fm_rd_page);
			end
			ST_PINV: begin
				if (fa_q) begin
					fm_we    = 1'b1;
					fm_waddr = vic_q;
					fm_wdata = {page_q, PIN_W'(1)};
					dctl.wr  = 1'b1;
					d_wdata  = {1'b1, vic_q};
				end
			end
			ST_AL1: begin
				if (free_top_q == '0) begin
					dctl.rd = 1'b1;
					d_raddr = DAW'(total_q);
				end
			end
			ST_AL2: begin
				dctl.rd = 1'b1;
				d_raddr = DAW'(stk_rd_q);
			end
			ST_AL3: begin
				fm_we    = 1'b1;
				fm_waddr = vic_q;
				fm_wdata = {id_q, PIN_W'(0)};
				dctl.wr  = 1'b1;
				d_waddr  = DAW'(id_q);
				d_wdata  = {1'b1, vic_q};
			end
			ST_FR1: begin
				dctl.wr = d_ent_v;
				stk_we  = (32'(free_top_q) < FREE_DEPTH);
			end
			ST_SW: begin
				fm_raddr = idx_q;
			end
			ST_SW2: begin
				if (act_q == ACT_ROLLBACK) begin
					dctl.wr = 1'b1;
					d_waddr = DAW'(fm_rd_page);
				end
			end
			default: ;
		endcase
	end

	// frame memory and free-id stack: one write, one registered read
	always_ff @(posedge clk) begin
		if (fm_we) begin
			fmem_q[fm_waddr] <= fm_wdata;
		end
		fm_rd_q <= fmem_q[fm_raddr];
		if (stk_we) begin
			stk_q[stk_waddr] <= page_q;
		end
		stk_rd_q <= stk_q[stk_raddr];
	end

	bpcm_dir #(
		.DEPTH (MAX_PAGES),
		.DW    (DEW)
	) u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.raddr  (d_raddr),
		.waddr  (d_waddr),
		.wdata  (d_wdata),
		.rdata  (d_rd),
		.ready  (dir_ready)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fa_q        <= 1'b0;
			wr_q        <= 1'b0;
			lo_q        <= 1'b0;
			total_q     <= '0;
			valid_q     <= '0;
			dirty_q     <= '0;
			logged_q    <= '0;
			ref_q       <= '0;
			hand_q      <= '0;
			free_top_q  <= '0;
			res_valid_q <= 1'b0;
			act_q       <= '0;
			page_q      <= '0;
			mdirty_q    <= 1'b0;
			back_q      <= '0;
			vic_q       <= '0;
			frm_q       <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			id_q        <= '0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && dir_ready) begin
						act_q    <= action;
						page_q   <= page_id;
						mdirty_q <= mark_dirty;
						back_q   <= rollback_pages;
						state_q  <= ST_DEC;
					end
				end
				ST_DEC: begin
					cnt_q <= '0;
					idx_q <= '0;
					case (act_q)
						ACT_PIN: begin
							if (32'(page_q) >= 32'(total_q)) begin
								res_valid_q <= 1'b1;
								res_q   <= mk_res(KIND_NONE, '0, page_q, STAT_RANGE, 1'b1);
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_LOOK;
							end
						end
						ACT_UNPIN, ACT_FREE: begin
							if (32'(page_q) >= MAX_PAGES) begin
								res_valid_q <= 1'b1;
								res_q   <= mk_res(KIND_NONE, '0, page_q,
									(act_q == ACT_FREE) ? STAT_RANGE : STAT_OK, 1'b1);
								state_q <= ST_IDLE;
							end else begin
								state_q <= (act_q == ACT_FREE) ? ST_FR1 : ST_UP1;
							end
						end
						ACT_ALLOCATE: begin
							if (free_top_q == '0 && 32'(total_q) >= MAX_PAGES) begin
								res_valid_q <= 1'b1;
								res_q   <= mk_res(KIND_NONE, '0, '0, STAT_RANGE, 1'b1);
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_VIC;
							end
						end
						ACT_COMMIT_SCAN, ACT_CHECKPOINT, ACT_ROLLBACK: begin
							state_q <= ST_SW;
						end
						ACT_COMMIT_DONE: begin
							if (lo_q) begin
								logged_q <= logged_q | (valid_q & dirty_q);
							end
							res_valid_q <= 1'b1;
							res_q   <= mk_res(KIND_NONE, '0, '0, STAT_OK, 1'b1);
							state_q <= ST_IDLE;
						end
						ACT_MARK_CLEAN: begin
							dirty_q     <= '0;
							logged_q    <= '0;
							res_valid_q <= 1'b1;
							res_q   <= mk_res(KIND_NONE, '0, '0, STAT_OK, 1'b1);
							state_q <= ST_IDLE;
						end
						default: begin
							res_valid_q <= 1'b1;
							res_q   <= mk_res(KIND_NONE, '0, '0, STAT_OK, 1'b1);
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_LOOK: begin
					// hit: fetch the pin count; miss: start the CLOCK search
					frm_q   <= d_ent_f;
					state_q <= d_ent_v ? ST_HIT : ST_VIC;
				end
				ST_HIT: begin
					ref_q[frm_q] <= 1'b1;
					res_valid_q  <= 1'b1;
					res_q   <= mk_res(KIND_HIT, FRAME_W'(frm_q), page_q, STAT_OK, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_UP1: begin
					frm_q <= d_ent_f;
					if (d_ent_v) begin
						state_q <= ST_UP2;
					end else begin
						res_valid_q <= 1'b1;
						res_q   <= mk_res(KIND_NONE, '0, page_q, STAT_OK, 1'b1);
						state_q <= ST_IDLE;
					end
				end
				ST_UP2: begin
					if (mdirty_q) begin
						dirty_q[frm_q]  <= 1'b1;
						logged_q[frm_q] <= 1'b0;
					end
					res_valid_q <= 1'b1;
					res_q   <= mk_res(KIND_NONE, FRAME_W'(frm_q), page_q, STAT_OK, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_VIC: begin
					if (cnt_q == CW'(2 * NUM_FRAMES)) begin
						// two full turns without a victim
						res_valid_q <= 1'b1;
						res_q <= mk_res(KIND_NONE, '0,
							(act_q == ACT_PIN) ? page_q : '0, STAT_NOFRAME, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						hand_q <= hand_nxt;
						cnt_q  <= cnt_q + 1'b1;
						vic_q  <= hand_q;
						if (!valid_q[hand_q]) begin
							state_q <= (act_q == ACT_PIN) ? ST_PINV : ST_AL1;
						end else begin
							state_q <= ST_VIC2;
						end
					end
				end
				ST_VIC2: begin
					if (v_rskip) begin
						ref_q[vic_q] <= 1'b0;
					end
					if (v_take) begin
						// write back a dirty victim, then drop it
						if (v_d) begin
							res_valid_q <= 1'b1;
							res_q <= mk_res(KIND_WBACK, FRAME_W'(vic_q), fm_rd_page,
								STAT_OK, 1'b0);
						end
						valid_q[vic_q]  <= 1'b0;
						dirty_q[vic_q]  <= 1'b0;
						logged_q[vic_q] <= 1'b0;
						ref_q[vic_q]    <= 1'b0;
						state_q <= (act_q == ACT_PIN) ? ST_PINV : ST_AL1;
					end else begin
						state_q <= ST_VIC;
					end
				end
				ST_PINV: begin
					res_valid_q <= 1'b1;
					if (fa_q) begin
						valid_q[vic_q]  <= 1'b1;
						dirty_q[vic_q]  <= 1'b0;
						logged_q[vic_q] <= 1'b0;
						ref_q[vic_q]    <= 1'b0;
						res_q <= mk_res(KIND_LOAD, FRAME_W'(vic_q), page_q, STAT_OK, 1'b1);
					end else begin
						res_q <= mk_res(KIND_NONE, FRAME_W'(vic_q), page_q, STAT_NOFILE, 1'b1);
					end
					state_q <= ST_IDLE;
				end
				ST_AL1: begin
					// pop a freed id, else grow the page count
					if (free_top_q != '0) begin
						free_top_q <= free_top_q - 1'b1;
						state_q    <= ST_AL2;
					end else begin
						id_q    <= PAGE_W'(total_q);
						total_q <= total_q + 1'b1;
						state_q <= ST_AL3;
					end
				end
				ST_AL2: begin
					id_q    <= stk_rd_q;
					state_q <= ST_AL3;
				end
				ST_AL3: begin
					// drop a frame that still holds the reused id
					if (d_ent_v) begin
						valid_q[d_ent_f]  <= 1'b0;
						dirty_q[d_ent_f]  <= 1'b0;
						logged_q[d_ent_f] <= 1'b0;
						ref_q[d_ent_f]    <= 1'b0;
					end
					valid_q[vic_q]  <= 1'b1;
					dirty_q[vic_q]  <= 1'b1;
					logged_q[vic_q] <= 1'b0;
					ref_q[vic_q]    <= 1'b1;
					res_valid_q <= 1'b1;
					res_q   <= mk_res(KIND_NONE, FRAME_W'(vic_q), id_q, STAT_OK, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_FR1: begin
					if (d_ent_v) begin
						valid_q[d_ent_f]  <= 1'b0;
						dirty_q[d_ent_f]  <= 1'b0;
						logged_q[d_ent_f] <= 1'b0;
						ref_q[d_ent_f]    <= 1'b0;
					end
					if (32'(free_top_q) < FREE_DEPTH) begin
						free_top_q <= free_top_q + 1'b1;
					end
					res_valid_q <= 1'b1;
					res_q <= mk_res(KIND_NONE, d_ent_v ? FRAME_W'(d_ent_f) : '0, page_q,
						STAT_OK, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_SW: begin
					if (sw_match[idx_q]) begin
						state_q <= ST_SW2;
					end else if (idx_end) begin
						if (act_q == ACT_ROLLBACK && 32'(back_q) < 32'(total_q)) begin
							total_q <= PTW'(back_q);
						end
						res_valid_q <= 1'b1;
						res_q   <= mk_res(KIND_NONE, '0, '0, STAT_OK, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SW2: begin
					case (act_q)
						ACT_COMMIT_SCAN: begin
							res_valid_q <= 1'b1;
							res_q <= mk_res(KIND_LOG, FRAME_W'(idx_q), fm_rd_page, STAT_OK,
								!sw_more);
						end
						ACT_CHECKPOINT: begin
							dirty_q[idx_q]  <= 1'b0;
							logged_q[idx_q] <= 1'b0;
							res_valid_q <= 1'b1;
							res_q <= mk_res(KIND_WBACK, FRAME_W'(idx_q), fm_rd_page, STAT_OK,
								!sw_more);
						end
						default: begin
							valid_q[idx_q]  <= 1'b0;
							dirty_q[idx_q]  <= 1'b0;
							logged_q[idx_q] <= 1'b0;
							ref_q[idx_q]    <= 1'b0;
						end
					endcase
					if (act_q != ACT_ROLLBACK && !sw_more) begin
						state_q <= ST_IDLE;
					end else if (idx_end) begin
						if (32'(back_q) < 32'(total_q)) begin
							total_q <= PTW'(back_q);
						end
						res_valid_q <= 1'b1;
						res_q   <= mk_res(KIND_NONE, '0, '0, STAT_OK, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SW;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration writes must arrive only while idle; the user must ensure it, the block does not enforce it
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FILE:     fa_q <= cfg_data[0];
					CFG_WRITABLE: wr_q <= cfg_data[0];
					CFG_LOG:      lo_q <= cfg_data[0];
					CFG_PAGES:    total_q <= (32'(cfg_data) > MAX_PAGES) ?
						PTW'(MAX_PAGES) : PTW'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	assign busy        = busy_w;
	assign cfg_ready   = 1'b1;
	assign res_valid   = res_valid_q;
	assign kind        = res_q.kind;
	assign frame       = res_q.frame;
	assign page_number = res_q.page;
	assign status      = res_q.status;
	assign last        = res_q.last;

	`BPCM_ASSERT_IMP(a_nonfinal_keeps_busy, clk, arst_n, res_valid_q && !res_q.last, busy_w)
	`BPCM_ASSERT_NXT(a_no_result_after_accept, clk, arst_n, start && !busy_w, !res_valid_q)
	`BPCM_ASSERT_IMP(a_error_is_final, clk, arst_n, res_valid_q && (res_q.status != STAT_OK), res_q.last)
endmodule
